FILE: design/wvfd_pkg.sv
// Package for the windowed velocity estimator with friction decay.
// Holds the item structs, op codes and reset constants; no dependencies.
`default_nettype none
package wvfd_pkg;

  localparam int unsigned WindowDepthDefault = 16;
  localparam logic [23:0] TimeoutReset  = 24'd100000;
  localparam logic [23:0] FrictionReset = 24'd327680;
  localparam logic [30:0] DragReset     = 31'd65536;
  localparam logic [63:0] UsPerSec      = 64'd1000000;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_FRICTION = 2'd1,
    CFG_DRAG     = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] motion_delta;
    logic [47:0]        sample_time_us;
    logic [19:0]        tick_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity;
    logic [4:0]         kept_samples;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] multiplicand;
    logic [63:0] multiplier;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [95:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

FILE: design/wvfd_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on wvfd_pkg for the request struct.
`default_nettype none
module wvfd_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wvfd_pkg::mul_req_t req_i,
  output logic                   busy_o,
  output logic [95:0]            product_o
);

  logic [95:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [63:0] mplier_q, mplier_d;
  logic        busy_q, busy_d;

  always_comb begin
    acc_d = acc_q;
    mcand_d = mcand_q;
    mplier_d = mplier_q;
    busy_d = busy_q;
    if (req_i.start) begin
      acc_d = '0;
      mcand_d = {32'd0, req_i.multiplicand};
      mplier_d = req_i.multiplier;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d = {mcand_q[94:0], 1'b0};
      mplier_d = {1'b0, mplier_q[63:1]};
      busy_d = (mplier_q[63:1] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mcand_q <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign busy_o = busy_q;
  assign product_o = acc_q;

endmodule
`default_nettype wire

FILE: design/wvfd_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on wvfd_pkg for the request struct.
`default_nettype none
module wvfd_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wvfd_pkg::div_req_t req_i,
  output logic                   busy_o,
  output logic [95:0]            quotient_o
);

  logic [95:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d, trial;
  logic [63:0] dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q[63:0], quo_q[95]} - {1'b0, dsr_q};
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      dsr_d = req_i.divisor;
      cnt_d = 7'd96;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial;
        quo_d = {quo_q[94:0], 1'b1};
      end else begin
        rem_d = {rem_q[63:0], quo_q[95]};
        quo_d = {quo_q[94:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      busy_d = (cnt_q != 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

FILE: design/windowed_velocity_with_friction_decay_top.sv
// Top level of the windowed velocity estimator with friction decay.
// Depends on wvfd_pkg, wvfd_mul and wvfd_div.
`default_nettype none
// One item is worked on at a time, and a finished result waits in an output register, so
// the next item can be taken while the result is held. A clear, an unused op or a tick on
// zero velocity goes straight from idle to the done state and then to the output register.
// An add does the first ring read, then walks the ring over the held samples, the new one
// included, then runs the bit-serial multiply by one million and the 96-bit serial divide;
// both are skipped, and the velocity set to zero, when no sample is kept or the age of the
// oldest kept sample is zero. A tick runs two serial multiplies and then the divide. A result
// that is held off delays the next one.
module windowed_velocity_with_friction_decay_top #(
  parameter int unsigned WINDOW_DEPTH = wvfd_pkg::WindowDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire wvfd_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output wvfd_pkg::out_item_t       out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [30:0]          cfg_data_i
);

  localparam int unsigned IdxW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(WINDOW_DEPTH);

  logic [23:0] timeout_q, friction_q;
  logic [30:0] drag_q;

  logic [31:0] dring_q [WINDOW_DEPTH];
  logic [47:0] tring_q [WINDOW_DEPTH];
  logic [31:0] d_rd_q;
  logic [47:0] t_rd_q;

  wvfd_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] head_q, rd_q, wr_q;
  logic [CntW-1:0] count_q, kept_q, scan_q;
  logic signed [39:0] sum_q;
  logic signed [31:0] vel_q;
  logic [47:0] oldest_q, now_q;
  logic        have_q, op_tick_q, phase_q;
  logic [19:0] dt_q;
  logic [63:0] mag_q, tot_q;
  logic        neg_q, outv_q, started_q;
  wvfd_pkg::out_item_t out_q;

  wvfd_pkg::mul_req_t mreq;
  wvfd_pkg::div_req_t dreq;
  logic        mbusy, dbusy;
  logic [95:0] mprod, dquo;

  wvfd_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .busy_o(mbusy), .product_o(mprod));
  wvfd_div u_div (.clk_i, .rst_ni, .req_i(dreq), .busy_o(dbusy), .quotient_o(dquo));

  logic        accept, done_go;
  logic [47:0] t_rd, age;
  logic [31:0] d_rd;
  logic        keep_it;
  logic [63:0] dur;
  logic [IdxW-1:0] start_idx, mem_wa;
  logic        mem_we;
  logic [31:0] mem_wd;
  logic [47:0] mem_wt;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != wvfd_pkg::ST_IDLE);
  assign done_go = (state_q == wvfd_pkg::ST_DONE) && (!outv_q || !out_stall_i);
  assign t_rd = t_rd_q;
  assign d_rd = d_rd_q;
  assign age = (now_q >= t_rd) ? now_q - t_rd : 48'd0;
  assign keep_it = (age <= {24'd0, timeout_q});
  assign dur = (have_q && now_q > oldest_q) ? {16'd0, now_q - oldest_q} : 64'd0;
  assign start_idx = (CntW'(head_q) >= count_q) ? IdxW'(CntW'(head_q) - count_q)
                                                : IdxW'(CntW'(head_q) + DepthC - count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      wvfd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item_i.op == wvfd_pkg::OP_ADD) begin
            state_d = wvfd_pkg::ST_PRIME;
          end else if (in_item_i.op == wvfd_pkg::OP_TICK && vel_q != '0) begin
            state_d = wvfd_pkg::ST_MUL;
          end else begin
            state_d = wvfd_pkg::ST_DONE;
          end
        end
      end
      wvfd_pkg::ST_PRIME: state_d = wvfd_pkg::ST_SCAN;
      wvfd_pkg::ST_SCAN: begin
        if (scan_q == '0) begin
          state_d = (dur == '0) ? wvfd_pkg::ST_DONE : wvfd_pkg::ST_MUL;
        end
      end
      wvfd_pkg::ST_MUL: begin
        if (started_q && !mbusy && (op_tick_q ? phase_q : 1'b1)) begin
          state_d = wvfd_pkg::ST_DIV;
        end
      end
      wvfd_pkg::ST_DIV: begin
        if (started_q && !dbusy) begin
          state_d = wvfd_pkg::ST_DONE;
        end
      end
      wvfd_pkg::ST_DONE: begin
        if (done_go) begin
          state_d = wvfd_pkg::ST_IDLE;
        end
      end
      default: state_d = wvfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mreq = '0;
    dreq = '0;
    if (state_q == wvfd_pkg::ST_MUL && !started_q) begin
      mreq.start = 1'b1;
      if (op_tick_q) begin
        mreq.multiplicand = phase_q ? {44'd0, dt_q} : {40'd0, friction_q};
        mreq.multiplier = phase_q ? tot_q : mag_q;
      end else begin
        mreq.multiplicand = mag_q;
        mreq.multiplier = wvfd_pkg::UsPerSec;
      end
    end
    if (state_q == wvfd_pkg::ST_DIV && !started_q) begin
      dreq.start = 1'b1;
      if (op_tick_q) begin
        dreq.dividend = {16'd0, mprod[95:16]} + {49'd0, drag_q} * {76'd0, dt_q};
        dreq.divisor = wvfd_pkg::UsPerSec;
      end else begin
        dreq.dividend = mprod;
        dreq.divisor = dur;
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = head_q;
    mem_wd = in_item_i.motion_delta;
    mem_wt = in_item_i.sample_time_us;
    if (state_q == wvfd_pkg::ST_IDLE) begin
      mem_we = accept && (in_item_i.op == wvfd_pkg::OP_ADD);
    end else if (state_q == wvfd_pkg::ST_SCAN && scan_q != '0 && keep_it) begin
      mem_we = 1'b1;
      mem_wa = wr_q;
      mem_wd = d_rd;
      mem_wt = t_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dring_q[mem_wa] <= mem_wd;
      tring_q[mem_wa] <= mem_wt;
    end
    d_rd_q <= dring_q[rd_q];
    t_rd_q <= tring_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wvfd_pkg::ST_IDLE;
      timeout_q <= wvfd_pkg::TimeoutReset;
      friction_q <= wvfd_pkg::FrictionReset;
      drag_q <= wvfd_pkg::DragReset;
      head_q <= '0;
      count_q <= '0;
      sum_q <= '0;
      vel_q <= '0;
      outv_q <= 1'b0;
      out_q <= '0;
      started_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          wvfd_pkg::CFG_TIMEOUT:  timeout_q <= cfg_data_i[23:0];
          wvfd_pkg::CFG_FRICTION: friction_q <= cfg_data_i[23:0];
          wvfd_pkg::CFG_DRAG:     drag_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (done_go) begin
        outv_q <= 1'b1;
        out_q.velocity <= vel_q;
        out_q.kept_samples <= 5'(count_q);
      end else if (outv_q && !out_stall_i) begin
        outv_q <= 1'b0;
      end
      case (state_q)
        wvfd_pkg::ST_IDLE: begin
          started_q <= 1'b0;
          phase_q <= 1'b0;
          if (accept) begin
            op_tick_q <= (in_item_i.op == wvfd_pkg::OP_TICK);
            now_q <= in_item_i.sample_time_us;
            dt_q <= in_item_i.tick_us;
            neg_q <= vel_q[31];
            mag_q <= vel_q[31] ? 64'(-{{32{vel_q[31]}}, vel_q}) : {32'd0, vel_q};
            if (in_item_i.op == wvfd_pkg::OP_CLEAR) begin
              vel_q <= '0;
            end
            if (in_item_i.op == wvfd_pkg::OP_ADD) begin
              head_q <= (head_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
              if (count_q == DepthC) begin
                rd_q <= (head_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
                wr_q <= (head_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
                scan_q <= DepthC;
              end else begin
                rd_q <= start_idx;
                wr_q <= start_idx;
                scan_q <= count_q + 1'b1;
              end
              kept_q <= '0;
              sum_q <= '0;
              have_q <= 1'b0;
            end
          end
        end
        wvfd_pkg::ST_PRIME: begin
          rd_q <= (rd_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : rd_q + 1'b1;
        end
        wvfd_pkg::ST_SCAN: begin
          if (scan_q != '0) begin
            if (keep_it) begin
              wr_q <= (wr_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : wr_q + 1'b1;
              kept_q <= kept_q + 1'b1;
              sum_q <= sum_q + 40'(signed'(d_rd));
              if (!have_q || t_rd < oldest_q) begin
                oldest_q <= t_rd;
              end
              have_q <= 1'b1;
            end
            rd_q <= (rd_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : rd_q + 1'b1;
            scan_q <= scan_q - 1'b1;
          end else begin
            count_q <= kept_q;
            head_q <= wr_q;
            neg_q <= sum_q[39];
            mag_q <= sum_q[39] ? 64'(-{{24{sum_q[39]}}, sum_q}) : {24'd0, sum_q};
            if (dur == '0) begin
              vel_q <= '0;
            end
          end
        end
        wvfd_pkg::ST_MUL: begin
          if (!started_q) begin
            started_q <= 1'b1;
          end else if (!mbusy) begin
            if (op_tick_q && !phase_q) begin
              tot_q <= mprod[63:0];
              phase_q <= 1'b1;
              started_q <= 1'b0;
            end else begin
              started_q <= 1'b0;
            end
          end
        end
        wvfd_pkg::ST_DIV: begin
          if (!started_q) begin
            started_q <= 1'b1;
          end else if (!dbusy) begin
            started_q <= 1'b0;
            if (op_tick_q) begin
              if (dquo >= {32'd0, mag_q}) begin
                vel_q <= '0;
              end else begin
                vel_q <= neg_q ? 32'(-(mag_q - dquo[63:0])) : 32'(mag_q - dquo[63:0]);
              end
            end else if (neg_q) begin
              vel_q <= (dquo >= 96'h8000_0000) ? 32'h8000_0000 : 32'(-dquo[31:0]);
            end else begin
              vel_q <= (dquo > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : dquo[31:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = outv_q;
  assign out_item_o = out_q;

endmodule
`default_nettype wire
